>>> rtl/lrcc_pkg.sv
// Shared types, codes and constants of the left-to-right character calculator.
package lrcc_pkg;

    // Characters that the expression may hold.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Result status codes.
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_LEADING  = 3'd1;
    localparam logic [2:0] ST_BADCHAR  = 3'd2;
    localparam logic [2:0] ST_MISSING  = 3'd3;
    localparam logic [2:0] ST_DIGITS   = 3'd4;
    localparam logic [2:0] ST_DIVZERO  = 3'd5;
    localparam logic [2:0] ST_OVERFLOW = 3'd6;

    localparam logic [63:0] VAL_POS_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] VAL_NEG_MIN = 64'h8000_0000_0000_0000;

    // Step counter of the shared shift unit and the length of a division.
    localparam int CNT_W     = 7;
    localparam int DIV_STEPS = 64;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        PH_START    = 2'd0,
        PH_OPERAND  = 2'd1,
        PH_AFTER_OP = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MAG,
        S_ADDSUB,
        S_MUL,
        S_DIV,
        S_PACK,
        S_EMIT
    } t_state;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_DIGIT,
        DP_MAG,
        DP_ADDSUB,
        DP_MUL_STEP,
        DP_DIV_STEP,
        DP_PACK,
        DP_EMIT
    } t_dp_op;

    typedef struct packed {
        t_dp_op     op;
        t_op        arith;
        logic       fresh;
        logic [3:0] digit;
        logic       hard;
        logic [2:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic opnd_zero;
        logic dcnt_full;
        logic pack_ovf;
    } t_dp_sts;

    // Bits that hold any decimal number of the given digit count.
    function automatic int opnd_width(input int digits);
        return (digits * 3322) / 1000 + 1;
    endfunction

endpackage

>>> rtl/lrcc_datapath.sv
// Datapath: operand collection, accumulator and the shared multiply/divide shift unit.
module lrcc_datapath #(
    parameter int MAX_DIGITS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  lrcc_pkg::t_dp_cmd     i_cmd,
    output lrcc_pkg::t_dp_sts     o_sts,
    output logic signed [63:0]    o_value,
    output logic [2:0]            o_status
);
    import lrcc_pkg::*;

    localparam int OPW = opnd_width(MAX_DIGITS);
    localparam int DCW = $clog2(MAX_DIGITS + 1);

    logic [63:0]        r_acc;
    logic [OPW-1:0]     r_opnd;
    logic [DCW-1:0]     r_dcnt;
    logic [63:0]        r_mag;
    logic [63:0]        r_work;
    logic [OPW-1:0]     r_rem;
    logic [OPW-1:0]     r_nsh;
    logic               r_ovf;
    logic               r_neg;
    logic signed [63:0] r_value;
    logic [2:0]         r_status;

    logic               acc_neg;
    logic [63:0]        acc_mag;
    logic [OPW+3:0]     opnd_x10;
    logic [OPW-1:0]     digit_next;
    logic [127:0]       mo_wide;
    logic [63:0]        mo;
    logic [64:0]        add_sum;
    logic [63:0]        dif_am;
    logic [63:0]        dif_ma;
    logic               sub_sign;
    logic               mul_top;
    logic [64:0]        mul_sum;
    logic [OPW:0]       rem_sh;
    logic [OPW+1:0]     div_dif;
    logic               borrow;
    logic [63:0]        pk_mag;
    logic [63:0]        pk_val;
    logic               pk_ovf;

    always_comb begin
        acc_neg    = r_acc[63];
        acc_mag    = acc_neg ? (~r_acc + 64'd1) : r_acc;

        opnd_x10   = ({4'b0, r_opnd} << 3) + ({4'b0, r_opnd} << 1)
                     + (OPW+4)'(i_cmd.digit);
        digit_next = i_cmd.fresh ? OPW'(i_cmd.digit) : opnd_x10[OPW-1:0];

        mo_wide    = 128'(r_opnd) << FRAC_BITS;
        mo         = (|mo_wide[127:64]) ? '1 : mo_wide[63:0];
        add_sum    = {1'b0, r_mag} + {1'b0, mo};
        dif_am     = r_mag - mo;
        dif_ma     = mo - r_mag;
        sub_sign   = (i_cmd.arith == OP_SUB);

        mul_top    = r_work[63];
        mul_sum    = {1'b0, r_work[62:0], 1'b0}
                     + (r_nsh[OPW-1] ? {1'b0, r_mag} : 65'd0);

        rem_sh     = {r_rem, r_work[63]};
        div_dif    = {1'b0, rem_sh} - {2'b0, r_opnd};
        borrow     = div_dif[OPW+1];

        pk_mag     = r_ovf ? '1 : r_work;
        if (r_neg) begin
            pk_ovf = pk_mag[63] && (|pk_mag[62:0]);
            pk_val = pk_ovf ? VAL_NEG_MIN : (~pk_mag + 64'd1);
        end else begin
            pk_ovf = pk_mag[63];
            pk_val = pk_ovf ? VAL_POS_MAX : pk_mag;
        end
    end

    assign o_sts.opnd_zero = (r_opnd == '0);
    assign o_sts.dcnt_full = (r_dcnt >= DCW'(MAX_DIGITS));
    assign o_sts.pack_ovf  = pk_ovf;
    assign o_value         = r_value;
    assign o_status        = r_status;

    // Expression state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_opnd <= '0;
            r_dcnt <= '0;
        end else begin
            unique case (i_cmd.op)
                DP_DIGIT: begin
                    r_opnd <= digit_next;
                    r_dcnt <= i_cmd.fresh ? DCW'(1) : r_dcnt + DCW'(1);
                end
                DP_PACK: begin
                    r_acc  <= pk_val;
                    r_opnd <= '0;
                    r_dcnt <= '0;
                end
                DP_EMIT: begin
                    r_acc  <= '0;
                    r_opnd <= '0;
                    r_dcnt <= '0;
                end
                default: begin
                end
            endcase
        end
    end

    // Working registers of the arithmetic unit and the result register.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_MAG: begin
                r_mag  <= acc_mag;
                r_neg  <= acc_neg;
                r_ovf  <= 1'b0;
                r_rem  <= '0;
                r_nsh  <= r_opnd;
                r_work <= (i_cmd.arith == OP_DIV) ? acc_mag : '0;
            end
            DP_ADDSUB: begin
                if (r_neg == sub_sign) begin
                    r_work <= add_sum[64] ? '1 : add_sum[63:0];
                end else if (r_mag >= mo) begin
                    r_work <= dif_am;
                end else begin
                    r_work <= dif_ma;
                    r_neg  <= sub_sign;
                end
            end
            DP_MUL_STEP: begin
                r_work <= mul_sum[63:0];
                r_ovf  <= r_ovf | mul_top | mul_sum[64];
                r_nsh  <= r_nsh << 1;
            end
            DP_DIV_STEP: begin
                r_rem  <= borrow ? rem_sh[OPW-1:0] : div_dif[OPW-1:0];
                r_work <= {r_work[62:0], ~borrow};
            end
            DP_EMIT: begin
                r_value  <= i_cmd.hard ? '0 : r_acc;
                r_status <= i_cmd.status;
            end
            default: begin
            end
        endcase
    end

endmodule

>>> rtl/lrcc_ctrl.sv
// Controller: character decoding, phase and error tracking, and sequencing of the datapath.
module lrcc_ctrl #(
    parameter int MAX_DIGITS = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_char_code,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output lrcc_pkg::t_dp_cmd  o_cmd,
    input  lrcc_pkg::t_dp_sts  i_sts
);
    import lrcc_pkg::*;

    localparam int OPW = opnd_width(MAX_DIGITS);
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(OPW - 1);
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_STEPS - 1);

    t_state           r_state, n_state;
    t_phase           r_phase, n_phase;
    t_op              r_pend_op, n_pend_op;
    t_op              r_next_op, n_next_op;
    logic [2:0]       r_err, n_err;
    logic             r_end, n_end;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;

    logic             hard;
    logic             in_acc;
    logic             is_digit;
    logic             is_op;
    t_op              char_op;
    logic             div_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= PH_START;
            r_pend_op   <= OP_ADD;
            r_next_op   <= OP_ADD;
            r_err       <= ST_OK;
            r_end       <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_pend_op   <= n_pend_op;
            r_next_op   <= n_next_op;
            r_err       <= n_err;
            r_end       <= n_end;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        hard     = (r_err != ST_OK) && (r_err != ST_OVERFLOW);
        in_acc   = i_in_valid && (r_state == S_IDLE);
        is_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        is_op    = 1'b1;
        priority if (i_char_code == CH_PLUS)  char_op = OP_ADD;
        else if (i_char_code == CH_MINUS)     char_op = OP_SUB;
        else if (i_char_code == CH_STAR)      char_op = OP_MUL;
        else if (i_char_code == CH_SLASH)     char_op = OP_DIV;
        else begin
            char_op = OP_ADD;
            is_op   = 1'b0;
        end
        div_zero = (r_pend_op == OP_DIV) && i_sts.opnd_zero;

        n_state     = r_state;
        n_phase     = r_phase;
        n_pend_op   = r_pend_op;
        n_next_op   = r_next_op;
        n_err       = r_err;
        n_end       = r_end;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;

        o_cmd.op     = DP_NOP;
        o_cmd.arith  = r_pend_op;
        o_cmd.fresh  = (r_phase != PH_OPERAND);
        o_cmd.digit  = i_char_code[3:0];
        o_cmd.hard   = hard;
        o_cmd.status = r_err;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    priority if (i_char_code == CH_NUL) begin
                        n_state = S_EMIT;
                        if (!hard && (r_phase == PH_OPERAND)) begin
                            if (div_zero) begin
                                n_err = ST_DIVZERO;
                            end else begin
                                n_end   = 1'b1;
                                n_state = S_MAG;
                            end
                        end else if (!hard && (r_phase == PH_AFTER_OP)) begin
                            n_err = ST_MISSING;
                        end
                    end else if (hard) begin
                        n_state = S_IDLE;
                    end else if (is_digit) begin
                        if ((r_phase == PH_OPERAND) && i_sts.dcnt_full) begin
                            n_err = ST_DIGITS;
                        end else begin
                            o_cmd.op = DP_DIGIT;
                            n_phase  = PH_OPERAND;
                        end
                    end else if (is_op) begin
                        if (r_phase == PH_OPERAND) begin
                            if (div_zero) begin
                                n_err = ST_DIVZERO;
                            end else begin
                                n_end     = 1'b0;
                                n_next_op = char_op;
                                n_state   = S_MAG;
                            end
                        end else if (r_phase == PH_AFTER_OP) begin
                            n_err = ST_MISSING;
                        end else begin
                            n_err = ST_LEADING;
                        end
                    end else begin
                        n_err = ST_BADCHAR;
                    end
                end
            end
            S_MAG: begin
                o_cmd.op = DP_MAG;
                n_cnt    = '0;
                unique case (r_pend_op)
                    OP_ADD, OP_SUB: n_state = S_ADDSUB;
                    OP_MUL:         n_state = S_MUL;
                    OP_DIV:         n_state = S_DIV;
                endcase
            end
            S_ADDSUB: begin
                o_cmd.op = DP_ADDSUB;
                n_state  = S_PACK;
            end
            S_MUL: begin
                o_cmd.op = DP_MUL_STEP;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == MUL_LAST) begin
                    n_state = S_PACK;
                end
            end
            S_DIV: begin
                o_cmd.op = DP_DIV_STEP;
                n_cnt    = r_cnt + CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    n_state = S_PACK;
                end
            end
            S_PACK: begin
                o_cmd.op = DP_PACK;
                if (i_sts.pack_ovf && (r_err == ST_OK)) begin
                    n_err = ST_OVERFLOW;
                end
                if (r_end) begin
                    n_state = S_EMIT;
                end else begin
                    n_pend_op = r_next_op;
                    n_phase   = PH_AFTER_OP;
                    n_state   = S_IDLE;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    o_cmd.op    = DP_EMIT;
                    n_out_valid = 1'b1;
                    n_phase     = PH_START;
                    n_pend_op   = OP_ADD;
                    n_err       = ST_OK;
                    n_end       = 1'b0;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/left_to_right_char_calculator_top.sv
// Top level of the left-to-right character calculator.
// The block evaluates an arithmetic expression that arrives one ASCII character per
// item on the input channel (i_in_valid, o_in_stall, i_char_code). Operators + - * /
// are applied strictly left to right with no precedence; operands are decimal numbers
// of up to MAX_DIGITS digits. The accumulator is signed 64-bit fixed point with
// FRAC_BITS fraction bits. A NUL character ends the expression and yields exactly one
// item on the output channel (o_out_valid, i_out_stall, o_value, o_status); all other
// characters yield no result. After the result is produced the block starts over.
// Characters other than NUL that need no arithmetic are taken without a stall. An operator or
// NUL that closes an operand runs the shared shift unit through the states MAG, then
// ADDSUB, MUL or DIV, then PACK: a multiply makes one step per bit of the operand width
// (27 bits for eight digits), a divide one quotient bit per step over the 64-bit
// accumulator. A NUL then passes through the EMIT state, which loads the output register.
// While the unit works, o_in_stall is high.
// The output register holds a result until it is taken; the block keeps accepting
// characters meanwhile and stalls for it only when a new result is ready before the old one
// left. Synchronous active-low reset clears the expression state and the output valid.
module left_to_right_char_calculator_top #(
    parameter int MAX_DIGITS = 8,
    parameter int FRAC_BITS  = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_char_code,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [63:0] o_value,
    output logic [2:0]         o_status
);
    import lrcc_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    // The controller decodes characters, keeps phase and error state and steps the unit.
    lrcc_ctrl #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_char_code (i_char_code),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_cmd       (dp_cmd),
        .i_sts       (dp_sts)
    );

    // The datapath holds the operand, the accumulator, the shift unit and the result.
    lrcc_datapath #(
        .MAX_DIGITS (MAX_DIGITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (dp_cmd),
        .o_sts    (dp_sts),
        .o_value  (o_value),
        .o_status (o_status)
    );

endmodule

>>> rtl/lrcc_checker.sv
// Port-level checker of the calculator and its bind to the top level.
module lrcc_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic [7:0]         i_char_code,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input logic signed [63:0] o_value,
    input logic [2:0]         o_status
);
    import lrcc_pkg::*;

    // A hard error always reports a zero value.
    a_hard_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_OK) && (o_status != ST_OVERFLOW))
            |-> (o_value == 64'sd0))
        else $error("hard error reported with a nonzero value");

    // Only defined status codes leave the block.
    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status <= ST_OVERFLOW))
        else $error("undefined status code");

    // An accepted NUL always takes the block out of the input-ready state.
    a_nul_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && (i_char_code == CH_NUL)) |=> o_in_stall)
        else $error("NUL accepted without producing a result");

    // A new result appears only directly after input was held off.
    a_rise_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without an ending character");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall)
            |=> (o_out_valid && $stable(o_value) && $stable(o_status)))
        else $error("stalled result changed");

endmodule

bind left_to_right_char_calculator_top lrcc_checker u_lrcc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .i_char_code (i_char_code),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_value     (o_value),
    .o_status    (o_status)
);
